// ----- sv/fuan_pkg.sv -----
package fuan_pkg;

    localparam int MAX_NEIGHBOURS = 16;
    localparam int ID_W    = 64;
    localparam int VAL_W   = 32;
    localparam int MODE_W  = 3;
    localparam int KIND_W  = 2;
    localparam int IDX_W   = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
    localparam int CNT_W   = $clog2(MAX_NEIGHBOURS + 1);
    localparam int DIV_W   = CNT_W + 1;
    localparam int ACC_W   = VAL_W + 1 + $clog2(2 * MAX_NEIGHBOURS + 1);
    localparam int STEP_W  = $clog2(ACC_W + 1);
    localparam int PADDR_W = 4;

    localparam logic [MODE_W-1:0] MODE_UP    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DOWN  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_VALUE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HDR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ENTRY = 3'd4;
    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_QUERY = 3'd6;

    localparam logic [KIND_W-1:0] KIND_HEAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPLY = 2'd2;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_NEIGHBOURS - 1);

    typedef struct packed {
        logic             load;
        logic             scan;
        logic             apply;
        logic             sum;
        logic             div_init;
        logic             div_step;
        logic             div_fin;
        logic             head;
        logic             upd;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              out_free;
        logic              cur_valid;
    } t_stat;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-VAL_W:0] hi;
        hi = v[ACC_W-1:VAL_W-1];
        if (&hi || ~|hi) begin
            return v[VAL_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            return {1'b0, {(VAL_W-1){1'b1}}};
        end
    endfunction

endpackage

// ----- sv/fuan_if.sv -----
interface fuan_in_if;
    logic                                valid;
    logic                                ready;
    logic [fuan_pkg::MODE_W-1:0]         mode;
    logic [fuan_pkg::ID_W-1:0]           peer_id;
    logic signed [fuan_pkg::VAL_W-1:0]   item_value;

    modport source (output valid, mode, peer_id, item_value, input ready);
    modport sink   (input valid, mode, peer_id, item_value, output ready);
endinterface

interface fuan_out_if;
    logic                                valid;
    logic                                ready;
    logic [fuan_pkg::KIND_W-1:0]         kind;
    logic [fuan_pkg::ID_W-1:0]           node_id;
    logic signed [fuan_pkg::VAL_W-1:0]   first_value;
    logic signed [fuan_pkg::VAL_W-1:0]   second_value;
    logic                                last;

    modport source (output valid, kind, node_id, first_value, second_value, last, input ready);
    modport sink   (input valid, kind, node_id, first_value, second_value, last, output ready);
endinterface

// ----- sv/fuan_ctrl.sv -----
module fuan_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  fuan_pkg::t_stat i_stat,
    output fuan_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_APPLY = 4'd2;
    localparam logic [3:0] S_SUM   = 4'd3;
    localparam logic [3:0] S_DIVI  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_FIN   = 4'd6;
    localparam logic [3:0] S_HEAD  = 4'd7;
    localparam logic [3:0] S_UPD   = 4'd8;

    logic [3:0]                  r_state, n_state;
    logic [fuan_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [fuan_pkg::STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_step     = r_step;
        o_cmd      = '0;
        o_cmd.idx  = r_idx;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.mode inside {fuan_pkg::MODE_UP, fuan_pkg::MODE_DOWN,
                                        fuan_pkg::MODE_HDR}) begin
                    o_cmd.scan = 1'b1;
                    if (r_idx == fuan_pkg::IDX_LAST) begin
                        n_idx   = '0;
                        n_state = S_APPLY;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (i_stat.mode != fuan_pkg::MODE_QUERY || i_stat.out_free) begin
                    o_cmd.apply = 1'b1;
                    n_idx       = '0;
                    n_state     = (i_stat.mode == fuan_pkg::MODE_TICK) ? S_SUM : S_IDLE;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                if (r_idx == fuan_pkg::IDX_LAST) begin
                    n_idx   = '0;
                    n_state = S_DIVI;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_step         = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == fuan_pkg::STEP_W'(fuan_pkg::ACC_W - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.div_fin = 1'b1;
                n_state       = S_HEAD;
            end
            S_HEAD: begin
                if (i_stat.out_free) begin
                    o_cmd.head = 1'b1;
                    n_idx      = '0;
                    n_state    = S_UPD;
                end
            end
            S_UPD: begin
                if (!i_stat.cur_valid || i_stat.out_free) begin
                    o_cmd.upd = 1'b1;
                    if (r_idx == fuan_pkg::IDX_LAST) begin
                        n_idx   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/fuan_dp.sv -----
module fuan_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fuan_pkg::t_cmd                      i_cmd,
    output fuan_pkg::t_stat                     o_stat,
    input  logic [fuan_pkg::MODE_W-1:0]         i_mode,
    input  logic [fuan_pkg::ID_W-1:0]           i_peer_id,
    input  logic signed [fuan_pkg::VAL_W-1:0]   i_item_value,
    input  logic [fuan_pkg::ID_W-1:0]           i_my_id,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [fuan_pkg::KIND_W-1:0]         o_kind,
    output logic [fuan_pkg::ID_W-1:0]           o_node_id,
    output logic signed [fuan_pkg::VAL_W-1:0]   o_first_value,
    output logic signed [fuan_pkg::VAL_W-1:0]   o_second_value,
    output logic                                o_last
);

    localparam int N = fuan_pkg::MAX_NEIGHBOURS;
    localparam int AW = fuan_pkg::ACC_W;

    logic [fuan_pkg::MODE_W-1:0]        r_mode;
    logic [fuan_pkg::ID_W-1:0]          r_peer;
    logic signed [fuan_pkg::VAL_W-1:0]  r_val;

    logic [N-1:0]                       r_valid;
    logic [fuan_pkg::ID_W-1:0]          r_id   [N];
    logic signed [fuan_pkg::VAL_W-1:0]  r_flow [N];
    logic signed [fuan_pkg::VAL_W-1:0]  r_est  [N];

    logic signed [fuan_pkg::VAL_W-1:0]  r_local, r_own;
    logic [fuan_pkg::IDX_W-1:0]         r_sslot;
    logic                               r_matched;

    logic                               r_found, r_hasfree;
    logic [fuan_pkg::IDX_W-1:0]         r_fslot, r_freeslot;

    logic signed [AW-1:0]               r_acc;
    logic [fuan_pkg::CNT_W-1:0]         r_cnt, r_n;
    logic [AW-1:0]                      r_q;
    logic [fuan_pkg::DIV_W-1:0]         r_r;
    logic                               r_neg;

    logic                               r_ovalid, r_last;
    logic [fuan_pkg::KIND_W-1:0]        r_kind;
    logic [fuan_pkg::ID_W-1:0]          r_nid;
    logic signed [fuan_pkg::VAL_W-1:0]  r_fv, r_sv;

    logic                               cur_valid, out_free;
    logic [fuan_pkg::ID_W-1:0]          cur_id;
    logic signed [fuan_pkg::VAL_W-1:0]  cur_flow, cur_est, upd_flow, neg_val;
    logic [fuan_pkg::DIV_W-1:0]         divisor;
    logic [fuan_pkg::DIV_W:0]           trial;
    logic                               qbit;
    logic signed [AW-1:0]               quo;

    assign cur_valid = r_valid[i_cmd.idx];
    assign cur_id    = r_id[i_cmd.idx];
    assign cur_flow  = r_flow[i_cmd.idx];
    assign cur_est   = r_est[i_cmd.idx];
    assign out_free  = !r_ovalid || i_out_ready;

    assign upd_flow = fuan_pkg::sat_val(AW'(cur_flow) + AW'(r_own) - AW'(cur_est));
    assign neg_val  = fuan_pkg::sat_val(-AW'(r_val));

    assign divisor = fuan_pkg::DIV_W'(r_cnt) + 1'b1;
    assign trial   = {r_r, r_q[AW-1]};
    assign qbit    = (trial >= {1'b0, divisor});
    assign quo     = r_neg ? -signed'(r_q) : signed'(r_q);

    assign o_stat.mode      = r_mode;
    assign o_stat.out_free  = out_free;
    assign o_stat.cur_valid = cur_valid;

    // input capture and table scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= '0;
            r_found   <= 1'b0;
            r_hasfree <= 1'b0;
        end else if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_found   <= 1'b0;
            r_hasfree <= 1'b0;
        end else if (i_cmd.scan) begin
            if (cur_valid && cur_id == r_peer && !r_found) begin
                r_found <= 1'b1;
            end
            if (!cur_valid && !r_hasfree) begin
                r_hasfree <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_peer <= i_peer_id;
            r_val  <= i_item_value;
        end
        if (i_cmd.scan && cur_valid && cur_id == r_peer && !r_found) begin
            r_fslot <= i_cmd.idx;
        end
        if (i_cmd.scan && !cur_valid && !r_hasfree) begin
            r_freeslot <= i_cmd.idx;
        end
    end

    // table and node state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_local   <= '0;
            r_own     <= '0;
            r_sslot   <= '0;
            r_matched <= 1'b1;
        end else begin
            if (i_cmd.apply) begin
                case (r_mode)
                    fuan_pkg::MODE_UP: begin
                        if (!r_found && r_hasfree) begin
                            r_valid[r_freeslot] <= 1'b1;
                        end
                    end
                    fuan_pkg::MODE_DOWN: begin
                        if (r_found) begin
                            r_valid[r_fslot] <= 1'b0;
                            if (!r_matched && r_fslot == r_sslot) begin
                                r_matched <= 1'b1;
                            end
                        end
                    end
                    fuan_pkg::MODE_VALUE: begin
                        r_local <= r_val;
                    end
                    fuan_pkg::MODE_HDR: begin
                        if (r_found) begin
                            r_sslot   <= r_fslot;
                            r_matched <= 1'b0;
                        end else if (r_hasfree) begin
                            r_valid[r_freeslot] <= 1'b1;
                            r_sslot             <= r_freeslot;
                            r_matched           <= 1'b0;
                        end else begin
                            r_matched <= 1'b1;
                        end
                    end
                    fuan_pkg::MODE_ENTRY: begin
                        if (!r_matched && r_peer == i_my_id) begin
                            r_matched <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.div_fin) begin
                r_own <= fuan_pkg::sat_val(quo);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            case (r_mode)
                fuan_pkg::MODE_UP: begin
                    if (!r_found && r_hasfree) begin
                        r_id[r_freeslot]   <= r_peer;
                        r_flow[r_freeslot] <= '0;
                        r_est[r_freeslot]  <= '0;
                    end
                end
                fuan_pkg::MODE_HDR: begin
                    if (r_found) begin
                        r_est[r_fslot] <= r_val;
                    end else if (r_hasfree) begin
                        r_id[r_freeslot]   <= r_peer;
                        r_flow[r_freeslot] <= '0;
                        r_est[r_freeslot]  <= r_val;
                    end
                end
                fuan_pkg::MODE_ENTRY: begin
                    if (!r_matched && r_peer == i_my_id) begin
                        r_flow[r_sslot] <= neg_val;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.upd && cur_valid) begin
            r_flow[i_cmd.idx] <= upd_flow;
            r_est[i_cmd.idx]  <= r_own;
        end
    end

    // sum, divide by count plus one
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_acc <= AW'(r_local);
            r_cnt <= '0;
        end else if (i_cmd.sum && cur_valid) begin
            r_acc <= r_acc + AW'(cur_est) - AW'(cur_flow);
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.div_init) begin
            r_neg <= r_acc[AW-1];
            r_q   <= r_acc[AW-1] ? AW'(-r_acc) : AW'(r_acc);
            r_r   <= '0;
        end else if (i_cmd.div_step) begin
            r_q <= {r_q[AW-2:0], qbit};
            r_r <= qbit ? fuan_pkg::DIV_W'(trial - {1'b0, divisor})
                        : fuan_pkg::DIV_W'(trial);
        end
        if (i_cmd.head) begin
            r_n <= fuan_pkg::CNT_W'(1);
        end else if (i_cmd.upd && cur_valid) begin
            r_n <= r_n + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.head || (i_cmd.upd && cur_valid) ||
                     (i_cmd.apply && r_mode == fuan_pkg::MODE_QUERY)) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.head) begin
            r_kind <= fuan_pkg::KIND_HEAD;
            r_nid  <= i_my_id;
            r_fv   <= r_own;
            r_sv   <= '0;
            r_last <= (r_cnt == '0);
        end else if (i_cmd.upd && cur_valid) begin
            r_kind <= fuan_pkg::KIND_ENTRY;
            r_nid  <= cur_id;
            r_fv   <= upd_flow;
            r_sv   <= '0;
            r_last <= (r_n == r_cnt);
        end else if (i_cmd.apply && r_mode == fuan_pkg::MODE_QUERY) begin
            r_kind <= fuan_pkg::KIND_REPLY;
            r_nid  <= '0;
            r_fv   <= r_local;
            r_sv   <= r_own;
            r_last <= 1'b1;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_kind         = r_kind;
    assign o_node_id      = r_nid;
    assign o_first_value  = r_fv;
    assign o_second_value = r_sv;
    assign o_last         = r_last;

endmodule

// ----- sv/flow_updating_average_node.sv -----
// One node of flow-updating averaging with a 16-entry neighbour table walked one slot per
// cycle, save where the walk waits on a stalled output. An input is taken only when the
// node is idle. Neighbour up, down and message header go through accept, table walk and
// apply; value change, message entry and query skip the walk. A tick skips it too, then
// makes a summing pass, a bit-serial divide by the neighbour count plus one, then a
// header and one pass that updates flows and sends one result per live neighbour, each
// waiting on the output when stalled. my_id is written over APB at addresses 0 to 7.
module flow_updating_average_node (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fuan_in_if.sink                           in_ch,
    fuan_out_if.source                        out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fuan_pkg::PADDR_W-1:0]      paddr,
    input  logic [fuan_pkg::ID_W-1:0]         pwdata,
    output logic [fuan_pkg::ID_W-1:0]         prdata,
    output logic                              pready
);

    logic [fuan_pkg::ID_W-1:0] r_my_id;
    fuan_pkg::t_cmd            cmd;
    fuan_pkg::t_stat           stat;

    assign pready = 1'b1;
    assign prdata = (paddr[fuan_pkg::PADDR_W-1] == 1'b0) ? r_my_id : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_id <= '0;
        end else if (psel && penable && pwrite && paddr[fuan_pkg::PADDR_W-1] == 1'b0) begin
            r_my_id <= pwdata;
        end
    end

    fuan_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fuan_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_mode         (in_ch.mode),
        .i_peer_id      (in_ch.peer_id),
        .i_item_value   (in_ch.item_value),
        .i_my_id        (r_my_id),
        .i_out_ready    (out_ch.ready),
        .o_out_valid    (out_ch.valid),
        .o_kind         (out_ch.kind),
        .o_node_id      (out_ch.node_id),
        .o_first_value  (out_ch.first_value),
        .o_second_value (out_ch.second_value),
        .o_last         (out_ch.last)
    );

endmodule

// ----- sv/fuan_checker.sv -----
module fuan_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [fuan_pkg::KIND_W-1:0]       i_kind,
    input logic [fuan_pkg::VAL_W-1:0]        i_second_value,
    input logic                              i_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) && $stable(i_last))
        else $error("stalled output transfer changed");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while busy");

    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == fuan_pkg::KIND_REPLY |-> i_last)
        else $error("query reply not last");

    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != fuan_pkg::KIND_REPLY |-> i_second_value == '0)
        else $error("second value nonzero outside reply");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind flow_updating_average_node fuan_checker u_fuan_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (in_ch.valid),
    .i_in_ready     (in_ch.ready),
    .i_out_valid    (out_ch.valid),
    .i_out_ready    (out_ch.ready),
    .i_kind         (out_ch.kind),
    .i_second_value (out_ch.second_value),
    .i_last         (out_ch.last)
);
